// ----- hw/rtl/crfm_pkg.sv -----
// ----------------------------------------------------------------------------
// crfm_pkg
// Shared operation codes and controller state type for the region merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package crfm_pkg;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CLEAR   = 3'd1;
   localparam logic [2:0] OP_POINT   = 3'd2;
   localparam logic [2:0] OP_OVERLAP = 3'd3;
   localparam logic [2:0] OP_INSIDE  = 3'd4;
   localparam logic [2:0] OP_EXTENTS = 3'd5;

   localparam logic [8:0] RATIO_MIN   = 9'd128;
   localparam logic [8:0] RATIO_MAX   = 9'd256;
   localparam logic [8:0] RATIO_RESET = 9'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DECIDE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/crfm_if.sv -----
// ----------------------------------------------------------------------------
// crfm_if
// Handshake channels of the region merge block: request, response, register.
// ----------------------------------------------------------------------------
`default_nettype none

interface crfm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [15:0] size_w;
   logic [15:0] size_h;
   modport source (output valid, op, pos_x, pos_y, size_w, size_h, input ready);
   modport sink   (input valid, op, pos_x, pos_y, size_w, size_h, output ready);
endinterface

interface crfm_rsp_if;
   logic        valid;
   logic        ready;
   logic        answer;
   logic [15:0] ext_x;
   logic [15:0] ext_y;
   logic [15:0] ext_w;
   logic [15:0] ext_h;
   logic        is_empty;
   logic [5:0]  entry_count;
   logic        overflowed;
   modport source (output valid, answer, ext_x, ext_y, ext_w, ext_h, is_empty,
                   entry_count, overflowed, input ready);
   modport sink   (input valid, answer, ext_x, ext_y, ext_w, ext_h, is_empty,
                   entry_count, overflowed, output ready);
endinterface

interface crfm_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/crfm_ram.sv -----
// ----------------------------------------------------------------------------
// crfm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module crfm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/clip_region_fuzzy_merge.sv -----
// ----------------------------------------------------------------------------
// clip_region_fuzzy_merge
// Damage rectangle table with fuzzy merge on add, and point, overlap,
// containment and extents queries over all stored rectangles.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   req      in   op, pos_x, pos_y, size_w, size_h
//   rsp      out  answer, ext_x/y/w/h, is_empty, entry_count, overflowed
//   csr      in   merge ratio (9 bits, Q1.8), always ready
// Each item walks the N stored rectangles: every entry takes a RAM read, an
// evaluate step (union, areas) and a decide step (ratio compare). Clear,
// zero-size add, unused ops and any op on an empty table skip the walk.
// Reset clears the entry count and the response valid flag; the RAM is not reset.
// A waiting response holds the finish step until it is taken.
`default_nettype none

module clip_region_fuzzy_merge #(
   parameter int MAX_RECTS  = 32,
   parameter int COORD_BITS = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   crfm_req_if.sink   req,
   crfm_rsp_if.source rsp,
   crfm_csr_if.sink   csr
);

   localparam int CW   = COORD_BITS;
   localparam int EW   = CW + 1;
   localparam int AW   = 2 * CW;
   localparam int PW   = AW + 9;
   localparam int RW   = 4 * CW;
   localparam int IW   = $clog2(MAX_RECTS);
   localparam int CNTW = $clog2(MAX_RECTS + 1);

   function automatic logic [CW-1:0] fx(input logic [RW-1:0] r);
      return r[4*CW-1:3*CW];
   endfunction
   function automatic logic [CW-1:0] fy(input logic [RW-1:0] r);
      return r[3*CW-1:2*CW];
   endfunction
   function automatic logic [CW-1:0] fw(input logic [RW-1:0] r);
      return r[2*CW-1:CW];
   endfunction
   function automatic logic [CW-1:0] fh(input logic [RW-1:0] r);
      return r[CW-1:0];
   endfunction

   function automatic logic [EW-1:0] fr(input logic [RW-1:0] r);
      return EW'(fx(r)) + EW'(fw(r));
   endfunction
   function automatic logic [EW-1:0] fb(input logic [RW-1:0] r);
      return EW'(fy(r)) + EW'(fh(r));
   endfunction

   function automatic logic [RW-1:0] unite(input logic [RW-1:0] a, input logic [RW-1:0] b);
      logic [CW-1:0] ux, uy, uw, uh;
      logic [EW-1:0] rr, rb, dw, dh;
      ux = (fx(a) < fx(b)) ? fx(a) : fx(b);
      uy = (fy(a) < fy(b)) ? fy(a) : fy(b);
      rr = (fr(a) > fr(b)) ? fr(a) : fr(b);
      rb = (fb(a) > fb(b)) ? fb(a) : fb(b);
      dw = rr - EW'(ux);
      dh = rb - EW'(uy);
      uw = dw[CW] ? {CW{1'b1}} : dw[CW-1:0];
      uh = dh[CW] ? {CW{1'b1}} : dh[CW-1:0];
      return {ux, uy, uw, uh};
   endfunction

   function automatic logic overlap(input logic [RW-1:0] a, input logic [RW-1:0] b);
      return (EW'(fx(a)) < fr(b)) && (EW'(fx(b)) < fr(a)) &&
             (EW'(fy(a)) < fb(b)) && (EW'(fy(b)) < fb(a));
   endfunction

   function automatic logic [15:0] to16(input logic [CW-1:0] v);
      return 16'(v);
   endfunction
   function automatic logic [15:0] sat16(input logic [CW-1:0] v);
      return (33'(v) > 33'(17'h0FFFF)) ? 16'hFFFF : 16'(v);
   endfunction

   crfm_pkg::state_type state_ff, state_in;

   logic [8:0]      ratio_ff, ratio_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] i_ff, i_in;
   logic [CNTW-1:0] n_ff, n_in;
   logic [2:0]      op_ff, op_in;
   logic [RW-1:0]   q_ff, q_in;
   logic [RW-1:0]   big_ff, big_in;
   logic [RW-1:0]   e_ff, e_in;
   logic [RW-1:0]   u_ff, u_in;
   logic [RW-1:0]   kb_ff, kb_in;
   logic            kept_ff, kept_in;
   logic            ident_ff, ident_in;
   logic            ovl_ff, ovl_in;
   logic            adj_ff, adj_in;
   logic [AW-1:0]   aa_ff, aa_in;
   logic [AW-1:0]   ba_ff, ba_in;
   logic [AW-1:0]   ua_ff, ua_in;
   logic            hit_ff, hit_in;
   logic            qov_ff, qov_in;
   logic            qin_ff, qin_in;
   logic            ans_ff, ans_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_answer_ff, rsp_answer_in;
   logic [15:0]     rsp_x_ff, rsp_x_in;
   logic [15:0]     rsp_y_ff, rsp_y_in;
   logic [15:0]     rsp_w_ff, rsp_w_in;
   logic [15:0]     rsp_h_ff, rsp_h_in;
   logic            rsp_empty_ff, rsp_empty_in;
   logic [5:0]      rsp_count_ff, rsp_count_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   logic            ram_we;
   logic [IW-1:0]   ram_waddr;
   logic [RW-1:0]   ram_wdata;
   logic [RW-1:0]   ram_rdata;

   logic            walk_start;
   logic            fin_go;
   logic            last_entry;
   logic            is_add_real;
   logic [8:0]      ratio_use;
   logic [PW-1:0]   lhs_a, lhs_b, rhs_u;
   logic            merge;
   logic            overflow;
   logic [RW-1:0]   final_box;

   crfm_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (i_ff[IW-1:0]),
      .rdata (ram_rdata)
   );

   assign csr.ready = 1'b1;

   assign is_add_real = (op_ff == crfm_pkg::OP_ADD) && (fw(q_ff) != '0) && (fh(q_ff) != '0);
   assign walk_start  = (count_ff != '0) &&
                        (is_add_real || op_ff == crfm_pkg::OP_POINT ||
                         op_ff == crfm_pkg::OP_OVERLAP || op_ff == crfm_pkg::OP_INSIDE ||
                         op_ff == crfm_pkg::OP_EXTENTS);
   assign last_entry  = (i_ff + CNTW'(1)) >= count_ff;
   assign fin_go      = !rsp_valid_ff || rsp.ready;

   assign ratio_use = (ratio_ff < crfm_pkg::RATIO_MIN) ? crfm_pkg::RATIO_MIN :
                      (ratio_ff > crfm_pkg::RATIO_MAX) ? crfm_pkg::RATIO_MAX : ratio_ff;
   assign lhs_a = PW'({aa_ff, 8'h00});
   assign lhs_b = PW'({ba_ff, 8'h00});
   assign rhs_u = PW'(ua_ff) * PW'(ratio_use);
   assign merge = ident_ff || (ovl_ff && (lhs_a >= rhs_u || lhs_b >= rhs_u)) ||
                  (!ovl_ff && adj_ff);

   assign overflow  = n_ff == CNTW'(MAX_RECTS);
   assign final_box = kept_ff ? unite(kb_ff, big_ff) : big_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crfm_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = crfm_pkg::ST_READ;
            end
         end
         crfm_pkg::ST_READ: begin
            state_in = walk_start || (i_ff != '0) ? crfm_pkg::ST_EVAL : crfm_pkg::ST_FINISH;
         end
         crfm_pkg::ST_EVAL: begin
            state_in = crfm_pkg::ST_DECIDE;
         end
         crfm_pkg::ST_DECIDE: begin
            state_in = last_entry ? crfm_pkg::ST_FINISH : crfm_pkg::ST_READ;
         end
         crfm_pkg::ST_FINISH: begin
            if (fin_go) begin
               state_in = crfm_pkg::ST_IDLE;
            end
         end
         default: state_in = crfm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = n_ff[IW-1:0];
      ram_wdata = e_ff;
      case (state_ff)
         crfm_pkg::ST_IDLE: begin
            req.ready = 1'b1;
         end
         crfm_pkg::ST_DECIDE: begin
            ram_we = (op_ff == crfm_pkg::OP_ADD) && !merge;
         end
         crfm_pkg::ST_FINISH: begin
            ram_we = fin_go && is_add_real;
            if (overflow) begin
               ram_waddr = '0;
               ram_wdata = final_box;
            end else begin
               ram_wdata = big_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      ratio_in      = ratio_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      n_in          = n_ff;
      op_in         = op_ff;
      q_in          = q_ff;
      big_in        = big_ff;
      e_in          = e_ff;
      u_in          = u_ff;
      kb_in         = kb_ff;
      kept_in       = kept_ff;
      ident_in      = ident_ff;
      ovl_in        = ovl_ff;
      adj_in        = adj_ff;
      aa_in         = aa_ff;
      ba_in         = ba_ff;
      ua_in         = ua_ff;
      hit_in        = hit_ff;
      qov_in        = qov_ff;
      qin_in        = qin_ff;
      ans_in        = ans_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (csr.valid) begin
         ratio_in = csr.data;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         crfm_pkg::ST_IDLE: begin
            if (req.valid) begin
               op_in   = req.op;
               q_in    = {CW'(req.pos_x), CW'(req.pos_y), CW'(req.size_w), CW'(req.size_h)};
               big_in  = {CW'(req.pos_x), CW'(req.pos_y), CW'(req.size_w), CW'(req.size_h)};
               i_in    = '0;
               n_in    = '0;
               kept_in = 1'b0;
               ans_in  = 1'b0;
            end
         end
         crfm_pkg::ST_EVAL: begin
            e_in     = ram_rdata;
            u_in     = unite(big_ff, ram_rdata);
            ident_in = big_ff == ram_rdata;
            ovl_in   = overlap(big_ff, ram_rdata);
            adj_in   = ((fy(big_ff) == fy(ram_rdata)) && (fh(big_ff) == fh(ram_rdata)) &&
                        ((fr(big_ff) >= EW'(fx(ram_rdata)) && fx(big_ff) <= fx(ram_rdata)) ||
                         (fr(ram_rdata) >= EW'(fx(big_ff)) && fx(ram_rdata) <= fx(big_ff)))) ||
                       ((fx(big_ff) == fx(ram_rdata)) && (fw(big_ff) == fw(ram_rdata)) &&
                        ((fb(big_ff) >= EW'(fy(ram_rdata)) && fy(big_ff) <= fy(ram_rdata)) ||
                         (fb(ram_rdata) >= EW'(fy(big_ff)) && fy(ram_rdata) <= fy(big_ff))));
            aa_in    = AW'(fw(big_ff)) * AW'(fh(big_ff));
            ba_in    = AW'(fw(ram_rdata)) * AW'(fh(ram_rdata));
            ua_in    = AW'(fw(unite(big_ff, ram_rdata))) * AW'(fh(unite(big_ff, ram_rdata)));
            hit_in   = fx(q_ff) >= fx(ram_rdata) && EW'(fx(q_ff)) < fr(ram_rdata) &&
                       fy(q_ff) >= fy(ram_rdata) && EW'(fy(q_ff)) < fb(ram_rdata);
            qov_in   = overlap(ram_rdata, q_ff);
            qin_in   = fx(ram_rdata) >= fx(q_ff) && fy(ram_rdata) >= fy(q_ff) &&
                       fr(ram_rdata) <= fr(q_ff) && fb(ram_rdata) <= fb(q_ff);
         end
         crfm_pkg::ST_DECIDE: begin
            i_in = i_ff + CNTW'(1);
            case (op_ff)
               crfm_pkg::OP_ADD: begin
                  if (merge) begin
                     big_in = ident_ff ? big_ff : u_ff;
                  end else begin
                     n_in    = n_ff + CNTW'(1);
                     kb_in   = kept_ff ? unite(kb_ff, e_ff) : e_ff;
                     kept_in = 1'b1;
                  end
               end
               crfm_pkg::OP_POINT: begin
                  ans_in = ans_ff | hit_ff;
               end
               crfm_pkg::OP_OVERLAP: begin
                  ans_in = ans_ff | qov_ff;
               end
               crfm_pkg::OP_INSIDE: begin
                  ans_in = (i_ff == '0 ? 1'b1 : ans_ff) & qin_ff;
               end
               crfm_pkg::OP_EXTENTS: begin
                  kb_in   = kept_ff ? unite(kb_ff, e_ff) : e_ff;
                  kept_in = 1'b1;
               end
               default: begin
                  ans_in = 1'b0;
               end
            endcase
         end
         crfm_pkg::ST_FINISH: begin
            if (fin_go) begin
               rsp_valid_in  = 1'b1;
               rsp_ovf_in    = 1'b0;
               rsp_answer_in = 1'b0;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_w_in      = '0;
               rsp_h_in      = '0;
               count_in      = count_ff;
               if (is_add_real) begin
                  if (overflow) begin
                     count_in   = CNTW'(1);
                     rsp_ovf_in = 1'b1;
                  end else begin
                     count_in = n_ff + CNTW'(1);
                  end
               end else if (op_ff == crfm_pkg::OP_CLEAR) begin
                  count_in = '0;
               end
               if (op_ff == crfm_pkg::OP_POINT || op_ff == crfm_pkg::OP_OVERLAP ||
                   op_ff == crfm_pkg::OP_INSIDE) begin
                  rsp_answer_in = ans_ff && (count_ff != '0);
               end
               if (op_ff == crfm_pkg::OP_EXTENTS && kept_ff) begin
                  rsp_x_in = to16(fx(kb_ff));
                  rsp_y_in = to16(fy(kb_ff));
                  rsp_w_in = sat16(fw(kb_ff));
                  rsp_h_in = sat16(fh(kb_ff));
               end
               rsp_empty_in = count_in == '0;
               rsp_count_in = 6'(count_in);
            end
         end
         default: begin
            i_in = i_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crfm_pkg::ST_IDLE;
         ratio_ff     <= crfm_pkg::RATIO_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ratio_ff     <= ratio_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      n_ff          <= n_in;
      op_ff         <= op_in;
      q_ff          <= q_in;
      big_ff        <= big_in;
      e_ff          <= e_in;
      u_ff          <= u_in;
      kb_ff         <= kb_in;
      kept_ff       <= kept_in;
      ident_ff      <= ident_in;
      ovl_ff        <= ovl_in;
      adj_ff        <= adj_in;
      aa_ff         <= aa_in;
      ba_ff         <= ba_in;
      ua_ff         <= ua_in;
      hit_ff        <= hit_in;
      qov_ff        <= qov_in;
      qin_ff        <= qin_in;
      ans_ff        <= ans_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.answer      = rsp_answer_ff;
   assign rsp.ext_x       = rsp_x_ff;
   assign rsp.ext_y       = rsp_y_ff;
   assign rsp.ext_w       = rsp_w_ff;
   assign rsp.ext_h       = rsp_h_ff;
   assign rsp.is_empty    = rsp_empty_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.overflowed  = rsp_ovf_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_RECTS))
      else $error("entry count above table depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == crfm_pkg::ST_DECIDE && ram_we) |-> (n_ff <= i_ff))
      else $error("kept entry written ahead of read pointer");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (count_ff == CNTW'(1)))
      else $error("overflow without collapse to one entry");
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire
